/* sv/obbot_pkg.sv */
// shared constants for the oriented box overlap test
package obbot_pkg;

    // width of one packed input field
    localparam int FIELD_BITS = 48;
    // number of input fields in one beat
    localparam int NUM_FIELDS = 10;
    // input tdata width, already whole bytes
    localparam int S_TDATA_BITS = FIELD_BITS * NUM_FIELDS;
    // output tdata width, one flag padded to a byte
    localparam int M_TDATA_BITS = 8;
    // parallel cutoff register
    localparam int CUTOFF_BITS = 15;
    localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 15'd16383;
    // fraction bits of the cutoff format
    localparam int CUTOFF_FRAC = 14;
    // pipeline depth of the datapath
    localparam int PIPE_STAGES = 5;

    // field positions inside the input beat
    localparam int F_A_CENTER = 0;
    localparam int F_A_AXIS0  = 1;
    localparam int F_A_HALF   = 4;
    localparam int F_B_CENTER = 5;
    localparam int F_B_AXIS0  = 6;
    localparam int F_B_HALF   = 9;

endpackage

/* sv/obbot_datapath.sv */
// five stage separating axis datapath for two oriented boxes
module obbot_datapath #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [obbot_pkg::S_TDATA_BITS-1:0]         beat,
    input  logic [obbot_pkg::CUTOFF_BITS-1:0]          cutoff,
    output logic                                       overlap
);

    localparam int CB   = COMPONENT_BITS;
    localparam int AF   = CB - 2;
    localparam int PADW = 3 * CB;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * CB;
    localparam int PDW  = 2 * CB + 1;
    localparam int RW   = 2 * CB + 2;
    localparam int DAW  = 2 * CB + 3;
    localparam int HPW  = CB + RW;
    localparam int FW   = 3 * CB + 6;
    localparam int EPW  = DAW + RW;
    localparam int EW   = 4 * CB + 7;
    localparam int LSH  = 2 * AF - obbot_pkg::CUTOFF_FRAC;

    // stage 0: unpacked components and center offset
    logic signed [CB-1:0] ax_reg [3][3];
    logic signed [CB-1:0] bx_reg [3][3];
    logic signed [DW-1:0] d_reg  [3];
    logic        [CB-1:0] ha_reg [4][3];
    logic        [CB-1:0] hb_reg [4][3];
    logic signed [CB-1:0] ax_next [3][3];
    logic signed [CB-1:0] bx_next [3][3];
    logic signed [DW-1:0] d_next  [3];
    logic        [CB-1:0] ha_next [3];
    logic        [CB-1:0] hb_next [3];

    always_comb
    begin
        logic [PADW-1:0] fa;
        logic [PADW-1:0] fb;
        logic [PADW-1:0] ca;
        logic [PADW-1:0] cb;
        logic [PADW-1:0] la;
        logic [PADW-1:0] lb;
        ca = PADW'(beat[obbot_pkg::F_A_CENTER*obbot_pkg::FIELD_BITS +: obbot_pkg::FIELD_BITS]);
        cb = PADW'(beat[obbot_pkg::F_B_CENTER*obbot_pkg::FIELD_BITS +: obbot_pkg::FIELD_BITS]);
        la = PADW'(beat[obbot_pkg::F_A_HALF*obbot_pkg::FIELD_BITS +: obbot_pkg::FIELD_BITS]);
        lb = PADW'(beat[obbot_pkg::F_B_HALF*obbot_pkg::FIELD_BITS +: obbot_pkg::FIELD_BITS]);
        for (int k = 0; k < 3; k++)
        begin
            d_next[k]  = DW'($signed(cb[k*CB +: CB])) - DW'($signed(ca[k*CB +: CB]));
            ha_next[k] = la[k*CB +: CB];
            hb_next[k] = lb[k*CB +: CB];
        end
        for (int i = 0; i < 3; i++)
        begin
            fa = PADW'(beat[(obbot_pkg::F_A_AXIS0+i)*obbot_pkg::FIELD_BITS
                            +: obbot_pkg::FIELD_BITS]);
            fb = PADW'(beat[(obbot_pkg::F_B_AXIS0+i)*obbot_pkg::FIELD_BITS
                            +: obbot_pkg::FIELD_BITS]);
            for (int k = 0; k < 3; k++)
            begin
                ax_next[i][k] = $signed(fa[k*CB +: CB]);
                bx_next[i][k] = $signed(fb[k*CB +: CB]);
            end
        end
    end

    // half lengths ride along stages 0 to 3
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= ax_next;
            bx_reg    <= bx_next;
            d_reg     <= d_next;
            ha_reg[0] <= ha_next;
            hb_reg[0] <= hb_next;
            for (int s = 1; s < 4; s++)
            begin
                ha_reg[s] <= ha_reg[s-1];
                hb_reg[s] <= hb_reg[s-1];
            end
        end
    end

    // stage 1: elementwise products for cosines and offset projections
    logic signed [PW-1:0]  pr_reg [3][3][3];
    logic signed [PDW-1:0] pa_reg [3][3];
    logic signed [PDW-1:0] pb_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa_reg[i][k] <= PDW'(ax_reg[i][k]) * PDW'(d_reg[k]);
                    pb_reg[i][k] <= PDW'(bx_reg[i][k]) * PDW'(d_reg[k]);
                    for (int j = 0; j < 3; j++)
                        pr_reg[i][j][k] <= PW'(ax_reg[i][k]) * PW'(bx_reg[j][k]);
                end
            end
        end
    end

    // stage 2: sums into cosine matrix, projections and parallel flag
    logic signed [RW-1:0]  r_reg  [3][3];
    logic        [RW-1:0]  ar_reg [3][3];
    logic signed [DAW-1:0] da_reg [3];
    logic signed [DAW-1:0] db_reg [3];
    logic                  par2_reg;
    logic signed [RW-1:0]  r_next  [3][3];
    logic        [RW-1:0]  ar_next [3][3];
    logic signed [DAW-1:0] da_next [3];
    logic signed [DAW-1:0] db_next [3];
    logic                  par2_next;

    always_comb
    begin
        logic [RW-1:0] lim;
        lim = RW'(cutoff) << LSH;
        par2_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            da_next[i] = DAW'(pa_reg[i][0]) + DAW'(pa_reg[i][1]) + DAW'(pa_reg[i][2]);
            db_next[i] = DAW'(pb_reg[i][0]) + DAW'(pb_reg[i][1]) + DAW'(pb_reg[i][2]);
            for (int j = 0; j < 3; j++)
            begin
                r_next[i][j] = RW'(pr_reg[i][j][0]) + RW'(pr_reg[i][j][1])
                             + RW'(pr_reg[i][j][2]);
                ar_next[i][j] = r_next[i][j][RW-1] ? RW'(-r_next[i][j]) : RW'(r_next[i][j]);
                if (ar_next[i][j] > lim)
                    par2_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            ar_reg   <= ar_next;
            da_reg   <= da_next;
            db_reg   <= db_next;
            par2_reg <= par2_next;
        end
    end

    // stage 3: radius and cross axis products
    logic [HPW-1:0]        fa_reg [3][3];
    logic [HPW-1:0]        fb_reg [3][3];
    logic [DAW-1:0]        la_reg [3];
    logic [DAW-1:0]        lb_reg [3];
    logic signed [EPW-1:0] ep1_reg [3][3];
    logic signed [EPW-1:0] ep2_reg [3][3];
    logic [HPW-1:0]        er_reg [3][3][4];
    logic                  par3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par3_reg <= par2_reg;
            for (int i = 0; i < 3; i++)
            begin
                la_reg[i] <= da_reg[i][DAW-1] ? DAW'(-da_reg[i]) : DAW'(da_reg[i]);
                lb_reg[i] <= db_reg[i][DAW-1] ? DAW'(-db_reg[i]) : DAW'(db_reg[i]);
                for (int k = 0; k < 3; k++)
                begin
                    fa_reg[i][k] <= HPW'(hb_reg[2][k]) * HPW'(ar_reg[i][k]);
                    fb_reg[i][k] <= HPW'(ha_reg[2][k]) * HPW'(ar_reg[k][i]);
                end
                for (int j = 0; j < 3; j++)
                begin
                    ep1_reg[i][j] <= EPW'(da_reg[(i+2)%3]) * EPW'(r_reg[(i+1)%3][j]);
                    ep2_reg[i][j] <= EPW'(da_reg[(i+1)%3]) * EPW'(r_reg[(i+2)%3][j]);
                    er_reg[i][j][0] <= HPW'(ha_reg[2][(i+1)%3]) * HPW'(ar_reg[(i+2)%3][j]);
                    er_reg[i][j][1] <= HPW'(ha_reg[2][(i+2)%3]) * HPW'(ar_reg[(i+1)%3][j]);
                    er_reg[i][j][2] <= HPW'(hb_reg[2][(j+1)%3]) * HPW'(ar_reg[i][(j+2)%3]);
                    er_reg[i][j][3] <= HPW'(hb_reg[2][(j+2)%3]) * HPW'(ar_reg[i][(j+1)%3]);
                end
            end
        end
    end

    // stage 4: face and cross axis compares
    logic sepf_reg;
    logic sepe_reg;
    logic par4_reg;
    logic sepf_next;
    logic sepe_next;

    always_comb
    begin
        logic [FW-1:0]        lhs_f;
        logic [FW-1:0]        rhs_f;
        logic signed [EW-1:0] dif;
        logic [EW-1:0]        lhs_e;
        logic [EW-1:0]        rhs_e;
        sepf_next = 1'b0;
        sepe_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lhs_f = FW'(la_reg[i]) << AF;
            rhs_f = (FW'(ha_reg[3][i]) << (2*AF)) + FW'(fa_reg[i][0])
                  + FW'(fa_reg[i][1]) + FW'(fa_reg[i][2]);
            if (lhs_f > rhs_f)
                sepf_next = 1'b1;
            lhs_f = FW'(lb_reg[i]) << AF;
            rhs_f = (FW'(hb_reg[3][i]) << (2*AF)) + FW'(fb_reg[i][0])
                  + FW'(fb_reg[i][1]) + FW'(fb_reg[i][2]);
            if (lhs_f > rhs_f)
                sepf_next = 1'b1;
            for (int j = 0; j < 3; j++)
            begin
                dif   = EW'(ep1_reg[i][j]) - EW'(ep2_reg[i][j]);
                lhs_e = dif[EW-1] ? EW'(-dif) : EW'(dif);
                rhs_e = (EW'(er_reg[i][j][0]) + EW'(er_reg[i][j][1])
                       + EW'(er_reg[i][j][2]) + EW'(er_reg[i][j][3])) << AF;
                if (lhs_e > rhs_e)
                    sepe_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sepf_reg <= sepf_next;
            sepe_reg <= sepe_next;
            par4_reg <= par3_reg;
        end
    end

    // cross axes only count when no pair is parallel
    assign overlap = !(sepf_reg || (!par4_reg && sepe_reg));

endmodule

/* sv/obb_overlap_test_unit.sv */
// top level of the oriented box overlap test
//
// Usage: each slave beat carries two oriented boxes (center, three axes and
// three half lengths per box, 48 bits per field). The master side returns one
// beat per input beat with bit 0 set when the boxes overlap and clear when a
// separating axis was found. Results come back in input order.
// cfg_wr_en writes cfg_wr_data into the parallel cutoff register; write it
// only while no beat is in flight.
// Each beat passes the five datapath stages and then the output register.
// Throughput: one beat per cycle unless the receiver stalls, set by the five
// stage datapath plus the output register, every stage holding one box pair.
// Reset clears all valid bits, the output valid and loads the cutoff with
// its default. When the receiver stalls with a result waiting, the whole
// pipeline holds and s_tready falls in the same cycle; nothing is dropped
// or repeated, and bubbles inside the pipeline stay in place.
module obb_overlap_test_unit #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_center, a_axis_0..2, a_half_lengths, b_center, b_axis_0..2,
    // b_half_lengths, 48 bits each from the lowest bit up
    input  logic [obbot_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // overlap in bit 0, rest zero
    output logic [obbot_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [obbot_pkg::CUTOFF_BITS-1:0]   cfg_wr_data
);

    logic [obbot_pkg::CUTOFF_BITS-1:0] cutoff_reg;
    logic [obbot_pkg::PIPE_STAGES-1:0] vld_reg;
    logic                              m_tvalid_reg;
    logic                              overlap_reg;
    logic                              en;
    logic                              overlap;

    // global advance: hold everything while a result waits
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(obbot_pkg::M_TDATA_BITS-1){1'b0}}, overlap_reg};

    // cutoff register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutoff_reg <= obbot_pkg::CUTOFF_RESET;
        else if (cfg_wr_en)
            cutoff_reg <= cfg_wr_data;
    end

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[obbot_pkg::PIPE_STAGES-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[obbot_pkg::PIPE_STAGES-1];
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (en)
            overlap_reg <= overlap;
    end

    obbot_datapath #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_datapath (
        .clk     (clk),
        .en      (en),
        .beat    (s_tdata),
        .cutoff  (cutoff_reg),
        .overlap (overlap)
    );

endmodule
